// ===== src/ycc_pkg.sv =====
// Shared types, constants and helpers for the YCbCr to RGB converter.
`timescale 1ns / 1ps

package ycc_pkg;

  // Register indexes of the configuration port
  localparam logic REG_MATRIX_SELECT = 1'b0;
  localparam logic REG_RANGE_SELECT  = 1'b1;

  // Matrix codes
  localparam logic MATRIX_BT601 = 1'b0;
  localparam logic MATRIX_BT709 = 1'b1;

  // Range codes
  localparam logic RANGE_FULL  = 1'b0;
  localparam logic RANGE_VIDEO = 1'b1;

  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 11;
  localparam int COEF_W   = 12;
  localparam int PROD_W   = 20;
  localparam int SUM_W    = 21;
  localparam int FRAC_W   = 10;

  // Luma offset and gains, 10 fractional bits
  localparam logic [SAMPLE_W:0] LUMA_OFFSET     = 9'd16;
  localparam logic [GAIN_W-1:0] VIDEO_LUMA_GAIN = 11'd1192;
  localparam logic [GAIN_W-1:0] FULL_LUMA_GAIN  = 11'd1024;

  // BT.601 coefficients
  localparam logic [COEF_W-1:0] BT601_CR_R = 12'd1634;
  localparam logic [COEF_W-1:0] BT601_CB_G = 12'd401;
  localparam logic [COEF_W-1:0] BT601_CR_G = 12'd832;
  localparam logic [COEF_W-1:0] BT601_CB_B = 12'd2066;

  // BT.709 coefficients
  localparam logic [COEF_W-1:0] BT709_CR_R = 12'd1836;
  localparam logic [COEF_W-1:0] BT709_CB_G = 12'd218;
  localparam logic [COEF_W-1:0] BT709_CR_G = 12'd546;
  localparam logic [COEF_W-1:0] BT709_CB_B = 12'd2164;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = 21'sd512;

  typedef struct packed {
    logic matrix_select;
    logic range_select;
  } cfg_t;

  // Floor-shift a rounded sum by the fraction width and saturate to 0..255
  function automatic logic [SAMPLE_W-1:0] clamp_u8(input logic signed [SUM_W-1:0] s);
    logic [SAMPLE_W-1:0] res;
    begin
      if (s[SUM_W-1]) begin
        res = '0;
      end else if (s[SUM_W-2:FRAC_W+SAMPLE_W] != '0) begin
        res = '1;
      end else begin
        res = s[FRAC_W+SAMPLE_W-1:FRAC_W];
      end
      return res;
    end
  endfunction

endpackage

// ===== src/ycc_core.sv =====
// Four-stage conversion pipeline with per-stage valid and ready.
`timescale 1ns / 1ps

module ycc_core (
  input  logic                           clk,
  input  logic                           rst,
  input  ycc_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ycc_pkg::SAMPLE_W-1:0]   in_luma,
  input  logic [ycc_pkg::SAMPLE_W-1:0]   in_cb,
  input  logic [ycc_pkg::SAMPLE_W-1:0]   in_cr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ycc_pkg::SAMPLE_W-1:0]   red,
  output logic [ycc_pkg::SAMPLE_W-1:0]   green,
  output logic [ycc_pkg::SAMPLE_W-1:0]   blue
);
  import ycc_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1 registers: centered operands and selected coefficients
  logic signed [SAMPLE_W:0]   y_ofs;
  logic        [GAIN_W-1:0]   gain;
  logic signed [SAMPLE_W-1:0] cb_c;
  logic signed [SAMPLE_W-1:0] cr_c;
  logic        [COEF_W-1:0]   k_r, k_gb, k_gr, k_b;

  // Stage 2 registers: products
  logic signed [PROD_W-1:0] lt, p_r, p_gb, p_gr, p_b;

  // Stage 3 registers: rounded sums
  logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

  // Full-width products
  logic signed [SAMPLE_W+GAIN_W+1:0]  lt_full;
  logic signed [SAMPLE_W+COEF_W:0]    p_r_full, p_gb_full, p_gr_full, p_b_full;

  // A stage loads when it is empty or the next stage takes its contents
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v4;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stage 1: remove offsets, pick gain and matrix
  always_ff @(posedge clk) begin
    if (rdy1) begin
      if (cfg.range_select == RANGE_VIDEO) begin
        y_ofs <= $signed({1'b0, in_luma} - LUMA_OFFSET);
        gain  <= VIDEO_LUMA_GAIN;
      end else begin
        y_ofs <= $signed({1'b0, in_luma});
        gain  <= FULL_LUMA_GAIN;
      end
      // Subtracting 128 flips the top bit into a two's complement sign
      cb_c <= $signed({~in_cb[SAMPLE_W-1], in_cb[SAMPLE_W-2:0]});
      cr_c <= $signed({~in_cr[SAMPLE_W-1], in_cr[SAMPLE_W-2:0]});
      if (cfg.matrix_select == MATRIX_BT709) begin
        k_r  <= BT709_CR_R;
        k_gb <= BT709_CB_G;
        k_gr <= BT709_CR_G;
        k_b  <= BT709_CB_B;
      end else begin
        k_r  <= BT601_CR_R;
        k_gb <= BT601_CB_G;
        k_gr <= BT601_CR_G;
        k_b  <= BT601_CB_B;
      end
    end
  end

  // Stage 2: multiply
  assign lt_full   = y_ofs * $signed({1'b0, gain});
  assign p_r_full  = cr_c * $signed({1'b0, k_r});
  assign p_gb_full = cb_c * $signed({1'b0, k_gb});
  assign p_gr_full = cr_c * $signed({1'b0, k_gr});
  assign p_b_full  = cb_c * $signed({1'b0, k_b});

  always_ff @(posedge clk) begin
    if (rdy2) begin
      lt   <= lt_full[PROD_W-1:0];
      p_r  <= p_r_full[PROD_W-1:0];
      p_gb <= p_gb_full[PROD_W-1:0];
      p_gr <= p_gr_full[PROD_W-1:0];
      p_b  <= p_b_full[PROD_W-1:0];
    end
  end

  // Stage 3: accumulate with rounding half
  always_ff @(posedge clk) begin
    if (rdy3) begin
      r_sum <= {lt[PROD_W-1], lt} + {p_r[PROD_W-1], p_r} + ROUND_HALF;
      g_sum <= {lt[PROD_W-1], lt} - {p_gb[PROD_W-1], p_gb}
             - {p_gr[PROD_W-1], p_gr} + ROUND_HALF;
      b_sum <= {lt[PROD_W-1], lt} + {p_b[PROD_W-1], p_b} + ROUND_HALF;
    end
  end

  // Stage 4: shift, saturate and hold for the output transaction
  always_ff @(posedge clk) begin
    if (rdy4) begin
      red   <= clamp_u8(r_sum);
      green <= clamp_u8(g_sum);
      blue  <= clamp_u8(b_sum);
    end
  end

`ifndef SYNTHESIS
  // An empty output stage lets every upstream stage move
  assert property (@(posedge clk) disable iff (rst) !v4 |-> in_ready)
    else $error("input stalled with an empty output stage");

  // A full pipeline facing a stalled output takes nothing
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !out_ready) |-> !in_ready)
    else $error("input taken while every stage is full and blocked");

  // An accepted transaction lands in stage 1
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted transaction lost at stage 1");

  // A negative red sum saturates to zero
  assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4 && r_sum[SUM_W-1]) |=> (red == '0))
    else $error("negative red sum not clamped to zero");
`endif

endmodule

// ===== src/ycbcr_to_rgb_converter_top.sv =====
// Top level of the YCbCr to RGB converter: configuration registers and stream ports.
//
//   Channel  Dir  Handshake           Payload
//   s_*      in   s_tvalid/s_tready   s_tdata: luma, cb_sample, cr_sample
//   m_*      out  m_tvalid/m_tready   m_tdata: red, green, blue
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One pixel per clock sustained while m_tready is high; an accepted pixel
// passes the four pipeline stages (select, multiply, sum, saturate) to m_tdata,
// the first stage register loading at the edge of its s_* transaction. Reset
// clears the stage valid bits and loads BT.601 and video range. A stalled output
// fills empty stages first; input stops only when all four stages hold a pixel.
`timescale 1ns / 1ps

module ycbcr_to_rgb_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] luma, [15:8] cb_sample, [23:16] cr_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);
  import ycc_pkg::*;

  cfg_t cfg;
  logic [SAMPLE_W-1:0] red, green, blue;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.matrix_select <= MATRIX_BT601;
      cfg.range_select  <= RANGE_VIDEO;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATRIX_SELECT: cfg.matrix_select <= cfg_data;
        REG_RANGE_SELECT:  cfg.range_select  <= cfg_data;
        default: ;
      endcase
    end
  end

  ycc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_luma   (s_tdata[7:0]),
    .in_cb     (s_tdata[15:8]),
    .in_cr     (s_tdata[23:16]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tdata = {blue, green, red};

endmodule
